// ----- rtl/core/spq_pkg.sv -----
// Package for the score priority queue: request/response beats, stored
// entry layout, operation codes and sequencer states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    // Default number of stored entries
    localparam int CAPACITY_DEF = 64;

    // Operation codes carried in the request beat
    localparam logic [1:0] OP_PROMOTE = 2'd0;
    localparam logic [1:0] OP_PEEK    = 2'd1;
    localparam logic [1:0] OP_POP     = 2'd2;

    // One request beat
    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] item_id;
        logic [15:0] new_score;
        logic        has_old_score;
        logic [15:0] prev_score;
    } t_req;

    // One result beat
    typedef struct packed {
        logic [15:0] result_item;
        logic        found;
        logic        overflow;
    } t_rsp;

    // One stored entry
    typedef struct packed {
        logic [15:0] item;
        logic [15:0] score;
    } t_entry;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_OLD,
        ST_SHIFT,
        ST_SCAN_NEW,
        ST_SCAN_BEST
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/core/spq_mem.sv -----
// Entry store of the score priority queue: one write port, one read port,
// registered read data. Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_mem #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY)
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  wire spq_pkg::t_entry i_wdata,
    input  wire logic            i_re,
    input  wire logic [AW-1:0]   i_raddr,
    output spq_pkg::t_entry      o_rdata
);
    import spq_pkg::*;

    t_entry r_mem [CAPACITY];
    t_entry r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, read data valid in the cycle after the read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/spq_ctrl.sv -----
// Sequencer of the score priority queue: scans the entry store, compacts it
// after a removal and appends new entries. Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    input  wire spq_pkg::t_req   i_req,
    output logic                 busy,
    output logic                 o_valid,
    output spq_pkg::t_rsp        o_rsp,
    // entry store
    output logic                 o_we,
    output logic [AW-1:0]        o_waddr,
    output spq_pkg::t_entry      o_wdata,
    output logic                 o_re,
    output logic [AW-1:0]        o_raddr,
    input  wire spq_pkg::t_entry i_rdata
);
    import spq_pkg::*;

    t_state        r_state, n_state;
    t_req          r_req, n_req;
    logic [CW-1:0] r_occ, n_occ;
    logic [CW-1:0] r_idx, n_idx;      // next read address
    logic          r_rvld, n_rvld;    // read data valid this cycle
    logic [AW-1:0] r_ridx, n_ridx;    // address of the data in flight
    logic          r_hit, n_hit;      // match found / best seen
    logic [AW-1:0] r_pos, n_pos;      // match or best position
    logic [15:0]   r_best_score, n_best_score;
    logic [15:0]   r_best_item, n_best_item;
    logic          r_valid, n_valid;
    t_rsp          r_rsp, n_rsp;

    logic          rd_issue;
    logic          scan_end;
    logic [15:0]   target_score;
    logic          match;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_occ   <= '0;
            r_rvld  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_rvld  <= n_rvld;
            r_valid <= n_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_idx        <= n_idx;
        r_ridx       <= n_ridx;
        r_hit        <= n_hit;
        r_pos        <= n_pos;
        r_best_score <= n_best_score;
        r_best_item  <= n_best_item;
        r_rsp        <= n_rsp;
    end

    // Read issue and scan bookkeeping
    assign rd_issue     = (r_state != ST_IDLE) && (r_idx < r_occ);
    assign scan_end     = (r_idx >= r_occ) && !r_rvld;
    assign target_score = (r_state == ST_SCAN_OLD) ? r_req.prev_score : r_req.new_score;
    assign match        = r_rvld && (i_rdata.item == r_req.item_id)
                          && (i_rdata.score == target_score);

    assign o_re    = rd_issue;
    assign o_raddr = r_idx[AW-1:0];

    // Next state and store writes
    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_occ        = r_occ;
        n_idx        = rd_issue ? r_idx + CW'(1) : r_idx;
        n_rvld       = rd_issue;
        n_ridx       = r_idx[AW-1:0];
        n_hit        = r_hit;
        n_pos        = r_pos;
        n_best_score = r_best_score;
        n_best_item  = r_best_item;
        n_valid      = 1'b0;
        n_rsp        = r_rsp;
        o_we         = 1'b0;
        o_waddr      = r_ridx - AW'(1);
        o_wdata      = i_rdata;

        case (r_state)
            ST_IDLE: begin
                n_idx  = '0;
                n_rvld = 1'b0;
                n_hit  = 1'b0;
                if (start) begin
                    n_req = i_req;
                    if (i_req.operation == OP_PROMOTE) begin
                        n_state = i_req.has_old_score ? ST_SCAN_OLD : ST_SCAN_NEW;
                    end else if (i_req.operation inside {OP_PEEK, OP_POP}) begin
                        n_state = ST_SCAN_BEST;
                    end else begin
                        // unused code: empty result right away
                        n_valid = 1'b1;
                        n_rsp   = '0;
                    end
                end
            end

            // find the first entry equal to the old pair
            ST_SCAN_OLD: begin
                if (match && !r_hit) begin
                    n_hit = 1'b1;
                    n_pos = r_ridx;
                end
                if (scan_end) begin
                    n_rvld = 1'b0;
                    n_hit  = 1'b0;
                    if (r_hit) begin
                        n_state = ST_SHIFT;
                        n_idx   = CW'(r_pos) + CW'(1);
                    end else begin
                        n_state = ST_SCAN_NEW;
                        n_idx   = '0;
                    end
                end
            end

            // move entries above the gap down one place
            ST_SHIFT: begin
                o_we = r_rvld;
                if (scan_end) begin
                    n_occ  = r_occ - CW'(1);
                    n_rvld = 1'b0;
                    n_hit  = 1'b0;
                    n_idx  = '0;
                    if (r_req.operation == OP_PROMOTE) begin
                        n_state = ST_SCAN_NEW;
                    end else begin
                        n_state             = ST_IDLE;
                        n_valid             = 1'b1;
                        n_rsp.result_item   = r_best_item;
                        n_rsp.found         = 1'b1;
                        n_rsp.overflow      = 1'b0;
                    end
                end
            end

            // look for the new pair, append when absent and the store is not full
            ST_SCAN_NEW: begin
                if (match) begin
                    n_hit = 1'b1;
                end
                if (scan_end) begin
                    n_state           = ST_IDLE;
                    n_valid           = 1'b1;
                    n_rsp.result_item = '0;
                    n_rsp.found       = 1'b0;
                    n_rsp.overflow    = 1'b0;
                    if (!r_hit) begin
                        if (r_occ == CW'(CAPACITY)) begin
                            n_rsp.overflow = 1'b1;
                        end else begin
                            o_we    = 1'b1;
                            o_waddr = r_occ[AW-1:0];
                            o_wdata = '{item: r_req.item_id, score: r_req.new_score};
                            n_occ   = r_occ + CW'(1);
                        end
                    end
                end
            end

            // oldest entry of the highest score
            ST_SCAN_BEST: begin
                if (r_rvld && (!r_hit || i_rdata.score > r_best_score)) begin
                    n_hit        = 1'b1;
                    n_pos        = r_ridx;
                    n_best_score = i_rdata.score;
                    n_best_item  = i_rdata.item;
                end
                if (scan_end) begin
                    n_rvld = 1'b0;
                    if (r_hit && r_req.operation == OP_POP) begin
                        n_state = ST_SHIFT;
                        n_idx   = CW'(r_pos) + CW'(1);
                    end else begin
                        n_state           = ST_IDLE;
                        n_valid           = 1'b1;
                        n_rsp.result_item = r_hit ? r_best_item : 16'd0;
                        n_rsp.found       = r_hit;
                        n_rsp.overflow    = 1'b0;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

`default_nettype wire

// ----- rtl/core/score_priority_queue_fifo_ties.sv -----
// Score priority queue with arrival order among equal scores: entries sit in
// one synchronous store, oldest first, and every promote, peek or pop walks
// it with one read per cycle. A peek scans the store once; a pop also closes
// the gap behind the popped place p, moving every newer entry down one
// place; a promote scans for the new pair and, when an old score is given,
// first scans for the old pair and, if found, compacts the store behind it.
// The single read port of the store paces these walks. busy is high while a
// command runs; the result beat appears on o_rsp with o_valid for exactly
// one cycle and cannot be held off, and a new command may start in that
// cycle. Depends on spq_pkg, spq_ctrl, spq_mem.
`timescale 1ns / 1ps
`default_nettype none

module score_priority_queue_fifo_ties #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire spq_pkg::t_req i_req,
    output logic               busy,
    output logic               o_valid,
    output spq_pkg::t_rsp      o_rsp
);
    import spq_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic          we;
    logic [AW-1:0] waddr;
    t_entry        wdata;
    logic          re;
    logic [AW-1:0] raddr;
    t_entry        rdata;

    // Command sequencer
    spq_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_valid (o_valid),
        .o_rsp   (o_rsp),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wdata (wdata),
        .o_re    (re),
        .o_raddr (raddr),
        .i_rdata (rdata)
    );

    // Entry store
    spq_mem #(
        .CAPACITY(CAPACITY)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule

`default_nettype wire
